// ===== hw/rtl/ddq_pkg.sv =====
// Shared types and constants for the bounded double-ended queue.
package ddq_pkg;

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_BACK   = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_READ       = 3'd4,
        MODE_CLEAR      = 3'd5
    } mode_t;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    typedef struct packed {
        logic                 valid;
        status_t              status;
        logic [COUNT_W-1:0]   count;
        logic                 use_data;
    } resp_t;

endpackage

// ===== hw/rtl/ddq_if.sv =====
// Valid/ready channel interfaces for command and result items.
interface ddq_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [ddq_pkg::MODE_W-1:0]    mode;
    logic [ddq_pkg::VALUE_W-1:0]   element_value;
    logic [ddq_pkg::POS_W-1:0]     position;

    modport source (output valid, output mode, output element_value, output position,
                    input ready);
    modport sink   (input valid, input mode, input element_value, input position,
                    output ready);
endinterface

interface ddq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ddq_pkg::VALUE_W-1:0]   read_value;
    logic [ddq_pkg::STATUS_W-1:0]  status;
    logic [ddq_pkg::COUNT_W-1:0]   item_count;

    modport source (output valid, output read_value, output status, output item_count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input item_count,
                    output ready);
endinterface

// ===== hw/rtl/ddq_ram.sv =====
// Single-port element store with registered read data.
module ddq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ddq_ctrl.sv =====
// Head/count bookkeeping, ring address generation and the access stage.
module ddq_ctrl #(
    parameter int DEPTH         = 256,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  logic [ddq_pkg::MODE_W-1:0]        mode,
    input  logic [ddq_pkg::VALUE_W-1:0]       element_value,
    input  logic [ddq_pkg::POS_W-1:0]         position,
    input  logic                              drain,
    output logic                              ram_we,
    output logic                              ram_re,
    output logic [$clog2(DEPTH)-1:0]          ram_addr,
    output logic [ELEMENT_WIDTH-1:0]          ram_wdata,
    output ddq_pkg::resp_t                    rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ((CW > ddq_pkg::POS_W) ? CW : ddq_pkg::POS_W) + 1;
    localparam int XW = (CW > ddq_pkg::COUNT_W) ? CW : ddq_pkg::COUNT_W;
    localparam int VW = (ELEMENT_WIDTH > ddq_pkg::VALUE_W) ? ELEMENT_WIDTH
                                                           : ddq_pkg::VALUE_W;

    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    ddq_pkg::resp_t     rsp_reg;

    logic               accept;
    logic               full, empty;
    logic [SW-1:0]      cnt_s, pos_s, off, sum, slot;
    logic [AW-1:0]      head_dec, head_inc;
    logic [XW-1:0]      count_x;
    logic [VW-1:0]      value_x;
    ddq_pkg::status_t   st;
    logic               use_data, we, re;
    logic [AW-1:0]      addr;

    assign cmd_ready = !rsp_reg.valid || drain;
    assign accept    = cmd_valid && cmd_ready;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign cnt_s    = SW'(count_reg);
    assign pos_s    = SW'(position);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign sum      = SW'(head_reg) + off;
    assign slot     = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
    assign value_x  = VW'(element_value);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        st         = ddq_pkg::ST_OK;
        use_data   = 1'b0;
        we         = 1'b0;
        re         = 1'b0;
        off        = '0;
        addr       = slot[AW-1:0];
        unique case (ddq_pkg::mode_t'(mode))
            ddq_pkg::MODE_PUSH_BACK:
            begin
                off = cnt_s;
                if (full)
                begin
                    st = ddq_pkg::ST_FULL;
                end
                else
                begin
                    we         = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            ddq_pkg::MODE_PUSH_FRONT:
            begin
                addr = head_dec;
                if (full)
                begin
                    st = ddq_pkg::ST_FULL;
                end
                else
                begin
                    we         = 1'b1;
                    head_next  = head_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            ddq_pkg::MODE_POP_BACK:
            begin
                off = cnt_s - SW'(1);
                if (empty)
                begin
                    st = ddq_pkg::ST_EMPTY;
                end
                else
                begin
                    re         = 1'b1;
                    use_data   = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            ddq_pkg::MODE_POP_FRONT:
            begin
                addr = head_reg;
                if (empty)
                begin
                    st = ddq_pkg::ST_EMPTY;
                end
                else
                begin
                    re         = 1'b1;
                    use_data   = 1'b1;
                    head_next  = head_inc;
                    count_next = count_reg - CW'(1);
                end
            end
            ddq_pkg::MODE_READ:
            begin
                off = pos_s;
                if (pos_s >= cnt_s)
                begin
                    st = ddq_pkg::ST_EMPTY;
                end
                else
                begin
                    re       = 1'b1;
                    use_data = 1'b1;
                end
            end
            ddq_pkg::MODE_CLEAR:
            begin
                head_next  = '0;
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign count_x   = XW'(count_next);
    assign ram_we    = accept && we;
    assign ram_re    = accept && re;
    assign ram_addr  = addr;
    assign ram_wdata = value_x[ELEMENT_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            rsp_reg   <= '0;
        end
        else if (accept)
        begin
            head_reg         <= head_next;
            count_reg        <= count_next;
            rsp_reg.valid    <= 1'b1;
            rsp_reg.status   <= st;
            rsp_reg.count    <= count_x[ddq_pkg::COUNT_W-1:0];
            rsp_reg.use_data <= use_data;
        end
        else if (drain)
        begin
            rsp_reg.valid <= 1'b0;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== hw/rtl/bounded_double_ended_queue_unit.sv =====
// Top level of the bounded double-ended queue: control, element store, result register.
//
//   channel  dir  payload                              accepted when
//   cmd      in   mode, element_value, position        cmd.valid && cmd.ready
//   rsp      out  read_value, status, item_count       rsp.valid && rsp.ready
//
// One item per cycle while the result is not stalled; a taken item passes through the
// store access stage, then the result register.
// The single store port is used at most once per item, which sets the rate.
// Reset clears head and count; store contents are undefined until pushed.
// A stalled result holds the access stage, and cmd.ready drops once it is full.
module bounded_double_ended_queue_unit #(
    parameter int DEPTH         = 256,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    ddq_cmd_if.sink    cmd,
    ddq_rsp_if.source  rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int VW = (ELEMENT_WIDTH > ddq_pkg::VALUE_W) ? ELEMENT_WIDTH
                                                           : ddq_pkg::VALUE_W;

    logic                          ram_we, ram_re;
    logic [AW-1:0]                 ram_addr;
    logic [ELEMENT_WIDTH-1:0]      ram_wdata, ram_rdata;
    logic [VW-1:0]                 rdata_x;
    ddq_pkg::resp_t                acc;
    logic                          drain;

    logic                          out_valid_reg;
    logic [ddq_pkg::VALUE_W-1:0]   read_value_reg;
    ddq_pkg::status_t              status_reg;
    logic [ddq_pkg::COUNT_W-1:0]   item_count_reg;

    ddq_ctrl #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd.valid),
        .cmd_ready     (cmd.ready),
        .mode          (cmd.mode),
        .element_value (cmd.element_value),
        .position      (cmd.position),
        .drain         (drain),
        .ram_we        (ram_we),
        .ram_re        (ram_re),
        .ram_addr      (ram_addr),
        .ram_wdata     (ram_wdata),
        .rsp           (acc)
    );

    ddq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ELEMENT_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign drain   = acc.valid && (!out_valid_reg || rsp.ready);
    assign rdata_x = VW'(ram_rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (drain)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            read_value_reg <= acc.use_data ? rdata_x[ddq_pkg::VALUE_W-1:0] : '0;
            status_reg     <= acc.status;
            item_count_reg <= acc.count;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.status     = status_reg;
    assign rsp.item_count = item_count_reg;

endmodule

// ===== hw/rtl/ddq_checker.sv =====
// Port-level checks for the bounded double-ended queue and their binding.
module ddq_checker #(
    parameter int DEPTH = 256
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [ddq_pkg::VALUE_W-1:0]     read_value,
    input logic [ddq_pkg::STATUS_W-1:0]    status,
    input logic [ddq_pkg::COUNT_W-1:0]     item_count
);

    localparam logic [ddq_pkg::COUNT_W-1:0] FULL_COUNT = ddq_pkg::COUNT_W'(DEPTH);

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == ddq_pkg::ST_OK || status == ddq_pkg::ST_EMPTY ||
                       status == ddq_pkg::ST_FULL))
        else $error("result status code out of range");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != ddq_pkg::ST_OK) |-> read_value == '0)
        else $error("failed operation returned nonzero value");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ddq_pkg::ST_FULL) |-> item_count == FULL_COUNT)
        else $error("full status with count below capacity");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(read_value) &&
                                       $stable(status) && $stable(item_count)))
        else $error("stalled result changed");

endmodule

bind bounded_double_ended_queue_unit ddq_checker #(
    .DEPTH (DEPTH)
) u_ddq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .read_value (rsp.read_value),
    .status     (rsp.status),
    .item_count (rsp.item_count)
);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the bounded double-ended queue unit.
`timescale 1ns / 1ps

module tb_top;

    localparam int QUEUE_DEPTH = 256;
    localparam logic [ddq_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [ddq_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam int REPORT_LIMIT = 10;

    typedef logic [ddq_pkg::POS_W-1:0] pos_t;

    typedef struct packed {
        logic [ddq_pkg::VALUE_W-1:0] read_value;
        ddq_pkg::status_t            status;
        logic [ddq_pkg::COUNT_W-1:0] item_count;
    } deque_result_t;

    class deque_scoreboard;
        logic [ddq_pkg::VALUE_W-1:0] held_values [QUEUE_DEPTH];
        logic [ddq_pkg::POS_W-1:0]   front_slot;
        logic [ddq_pkg::COUNT_W-1:0] held_count;
        deque_result_t               awaited[$];
        int                          mismatches;

        function new();
            front_slot = '0;
            held_count = '0;
            mismatches = 0;
            foreach (held_values[i])
                held_values[i] = '0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_command(logic [ddq_pkg::MODE_W-1:0] mode,
                                   logic [ddq_pkg::VALUE_W-1:0] value,
                                   logic [ddq_pkg::POS_W-1:0] position);
            deque_result_t res;
            logic [ddq_pkg::POS_W-1:0] slot;
            res = '{read_value: '0, status: ddq_pkg::ST_OK, item_count: '0};
            case (mode)
                ddq_pkg::MODE_PUSH_BACK:
                    if (held_count >= QUEUE_DEPTH)
                        res.status = ddq_pkg::ST_FULL;
                    else
                    begin
                        slot = front_slot + held_count[ddq_pkg::POS_W-1:0];
                        held_values[slot] = value;
                        held_count++;
                    end
                ddq_pkg::MODE_PUSH_FRONT:
                    if (held_count >= QUEUE_DEPTH)
                        res.status = ddq_pkg::ST_FULL;
                    else
                    begin
                        front_slot = front_slot - 1'b1;
                        held_values[front_slot] = value;
                        held_count++;
                    end
                ddq_pkg::MODE_POP_BACK:
                    if (held_count == 0)
                        res.status = ddq_pkg::ST_EMPTY;
                    else
                    begin
                        slot = front_slot + held_count[ddq_pkg::POS_W-1:0] - 1'b1;
                        res.read_value = held_values[slot];
                        held_count--;
                    end
                ddq_pkg::MODE_POP_FRONT:
                    if (held_count == 0)
                        res.status = ddq_pkg::ST_EMPTY;
                    else
                    begin
                        res.read_value = held_values[front_slot];
                        front_slot = front_slot + 1'b1;
                        held_count--;
                    end
                ddq_pkg::MODE_READ:
                    if ({1'b0, position} >= held_count)
                        res.status = ddq_pkg::ST_EMPTY;
                    else
                    begin
                        slot = front_slot + position;
                        res.read_value = held_values[slot];
                    end
                ddq_pkg::MODE_CLEAR:
                begin
                    front_slot = '0;
                    held_count = '0;
                end
                default:
                    ;
            endcase
            res.item_count = held_count;
            awaited.push_back(res);
        endfunction

        function void check_result(logic [ddq_pkg::VALUE_W-1:0] read_value,
                                   ddq_pkg::status_t status,
                                   logic [ddq_pkg::COUNT_W-1:0] item_count);
            deque_result_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with no item waiting: value %h status %0d count %0d",
                             $realtime, read_value, status, item_count);
                return;
            end
            want = awaited.pop_front();
            if (read_value !== want.read_value || status !== want.status ||
                item_count !== want.item_count)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: mismatch: exp value %h status %0d count %0d, got %h %0d %0d",
                             $realtime, want.read_value, want.status, want.item_count,
                             read_value, status, item_count);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   quiet_tail = 1'b0;
    int   stall_left = 0;

    ddq_cmd_if cmd_ch ();
    ddq_rsp_if rsp_ch ();

    deque_scoreboard sb = new();

    bounded_double_ended_queue_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.read_value, rsp_ch.status, rsp_ch.item_count);
            if (quiet_tail)
                rsp_ch.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic issue_op(input logic [ddq_pkg::MODE_W-1:0] mode,
                            input logic [ddq_pkg::VALUE_W-1:0] value,
                            input logic [ddq_pkg::POS_W-1:0] position);
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.mode          <= mode;
        cmd_ch.element_value <= value;
        cmd_ch.position      <= position;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sb.note_command(mode, value, position);
    endtask

    task automatic push_random();
        issue_op($urandom_range(0, 1) ? ddq_pkg::MODE_PUSH_FRONT : ddq_pkg::MODE_PUSH_BACK,
                 $urandom, '0);
    endtask

    task automatic pop_random();
        issue_op($urandom_range(0, 1) ? ddq_pkg::MODE_POP_FRONT : ddq_pkg::MODE_POP_BACK,
                 $urandom, pos_t'($urandom_range(0, 255)));
    endtask

    task automatic read_held();
        if (sb.held_count == 0)
            issue_op(ddq_pkg::MODE_READ, $urandom, pos_t'($urandom_range(0, 255)));
        else
            issue_op(ddq_pkg::MODE_READ, $urandom,
                     pos_t'($urandom_range(0, sb.held_count - 1)));
    endtask

    task automatic mixed_ops(input int n);
        int pick;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 36)
                push_random();
            else if (pick < 60)
                pop_random();
            else if (pick < 84)
                read_held();
            else if (pick < 92)
                issue_op(ddq_pkg::MODE_READ, $urandom, pos_t'($urandom_range(0, 255)));
            else if (pick < 94)
                issue_op(ddq_pkg::MODE_CLEAR, $urandom, pos_t'($urandom_range(0, 255)));
            else if (pick < 97)
                issue_op($urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO, $urandom,
                         pos_t'($urandom_range(0, 255)));
            else
                push_random();
        end
    endtask

    // fill to full, poke past the ends, drain to empty
    task automatic fill_and_drain();
        while (sb.held_count < QUEUE_DEPTH)
            if ($urandom_range(0, 9) == 0)
                read_held();
            else
                push_random();
        repeat ($urandom_range(1, 4)) push_random();
        issue_op(ddq_pkg::MODE_READ, $urandom, 8'd255);
        issue_op(ddq_pkg::MODE_READ, $urandom, 8'd0);
        repeat (4) read_held();
        while (sb.held_count > 0)
            if ($urandom_range(0, 9) == 0)
                read_held();
            else
                pop_random();
        repeat ($urandom_range(1, 3)) pop_random();
    endtask

    initial
    begin
        cmd_ch.valid         = 1'b0;
        cmd_ch.mode          = ddq_pkg::MODE_PUSH_BACK;
        cmd_ch.element_value = '0;
        cmd_ch.position      = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_op(ddq_pkg::MODE_POP_BACK, 32'h0, 8'd0);
        issue_op(ddq_pkg::MODE_POP_FRONT, 32'hFFFF_FFFF, 8'd255);
        issue_op(ddq_pkg::MODE_READ, 32'h0, 8'd0);
        issue_op(ddq_pkg::MODE_PUSH_BACK, 32'h0000_0000, 8'd0);
        issue_op(ddq_pkg::MODE_PUSH_FRONT, 32'hFFFF_FFFF, 8'd0);
        issue_op(ddq_pkg::MODE_PUSH_BACK, 32'hA5A5_A5A5, 8'hFF);
        issue_op(ddq_pkg::MODE_READ, 32'h0, 8'd0);
        issue_op(ddq_pkg::MODE_READ, 32'h0, 8'd2);
        issue_op(ddq_pkg::MODE_READ, 32'h0, 8'd3);
        issue_op(ddq_pkg::MODE_READ, 32'h0, 8'd255);
        issue_op(ddq_pkg::MODE_POP_BACK, 32'h0, 8'd0);
        issue_op(ddq_pkg::MODE_POP_FRONT, 32'h0, 8'd0);
        issue_op(MODE_SPARE_LO, 32'h1234_5678, 8'd1);
        issue_op(MODE_SPARE_HI, 32'hFFFF_FFFF, 8'd255);
        issue_op(ddq_pkg::MODE_CLEAR, 32'h0, 8'd0);
        issue_op(ddq_pkg::MODE_READ, 32'h0, 8'd0);
        issue_op(ddq_pkg::MODE_PUSH_FRONT, 32'h5A5A_5A5A, 8'd0);
        issue_op(ddq_pkg::MODE_PUSH_FRONT, 32'h8000_0001, 8'd0);
        issue_op(ddq_pkg::MODE_READ, 32'h0, 8'd1);
        issue_op(ddq_pkg::MODE_POP_BACK, 32'h0, 8'd0);
        issue_op(ddq_pkg::MODE_CLEAR, 32'h0, 8'd0);
        issue_op(ddq_pkg::MODE_CLEAR, 32'h0, 8'd0);
        issue_op(ddq_pkg::MODE_PUSH_BACK, 32'h0000_0001, 8'd0);

        mixed_ops(250);
        fill_and_drain();

        // hold off until the queue of results has drained
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);

        mixed_ops(200);
        quiet_tail = 1'b1;
        fill_and_drain();
        mixed_ops(150);

        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
